/* rtl/core/prt_pkg.sv */
package prt_pkg;

    // default table size and the widest slot index any size needs
    localparam int TABLE_DEPTH_DEF = 256;
    localparam int SLOT_W          = 12;

    // field widths of the request and response
    localparam int OP_W    = 3;
    localparam int ID_W    = 9;
    localparam int PRIO_W  = 8;
    localparam int ST_W    = 3;
    localparam int CNT_W   = 9;

    // opcodes
    localparam logic [OP_W-1:0] OP_SCHEDULE   = 3'd0;
    localparam logic [OP_W-1:0] OP_DISPATCH   = 3'd1;
    localparam logic [OP_W-1:0] OP_FINISH     = 3'd2;
    localparam logic [OP_W-1:0] OP_CANCEL     = 3'd3;
    localparam logic [OP_W-1:0] OP_QUERY      = 3'd4;
    localparam logic [OP_W-1:0] OP_CANCEL_ALL = 3'd5;
    localparam logic [OP_W-1:0] OP_CLEAR      = 3'd6;

    // task states
    localparam logic [ST_W-1:0] ST_PENDING   = 3'd0;
    localparam logic [ST_W-1:0] ST_RUNNING   = 3'd1;
    localparam logic [ST_W-1:0] ST_DONE      = 3'd2;
    localparam logic [ST_W-1:0] ST_CANCELLED = 3'd3;
    localparam logic [ST_W-1:0] ST_ERROR     = 3'd4;

    // response status codes
    localparam logic [2:0] RC_OK           = 3'd0;
    localparam logic [2:0] RC_FULL         = 3'd1;
    localparam logic [2:0] RC_NOT_FOUND    = 3'd2;
    localparam logic [2:0] RC_OVER         = 3'd3;
    localparam logic [2:0] RC_NONE_PENDING = 3'd4;
    localparam logic [2:0] RC_STOPPED      = 3'd5;
    localparam logic [2:0] RC_NONE_RUNNING = 3'd6;

    localparam logic [CNT_W-1:0] ERR_MAX = 9'd511;

    // commands broadcast to the cells
    localparam logic [1:0] CMD_NONE       = 2'd0;
    localparam logic [1:0] CMD_WRITE      = 2'd1;
    localparam logic [1:0] CMD_SET_STATE  = 2'd2;
    localparam logic [1:0] CMD_CANCEL_ALL = 2'd3;

    typedef struct packed {
        logic [1:0]        op;
        logic [SLOT_W-1:0] slot;
        logic [ST_W-1:0]   state;
        logic [PRIO_W-1:0] prio;
    } t_cell_cmd;

    // best pending candidate handed from cell to cell
    typedef struct packed {
        logic              found;
        logic [PRIO_W-1:0] prio;
        logic [SLOT_W-1:0] slot;
    } t_cand;

endpackage

/* rtl/core/prt_ifs.sv */
interface prt_req_if;
    logic       valid;
    logic       ready;
    logic [2:0] opcode;
    logic [8:0] task_id;
    logic [7:0] priority_req;
    logic       task_ok;

    modport source (output valid, opcode, task_id, priority_req, task_ok, input ready);
    modport sink   (input valid, opcode, task_id, priority_req, task_ok, output ready);
endinterface

interface prt_rsp_if;
    logic       valid;
    logic       ready;
    logic [2:0] status;
    logic [8:0] result_id;
    logic [2:0] task_state;
    logic [7:0] result_priority;
    logic [8:0] active_count;
    logic [8:0] fail_count;

    modport source (output valid, status, result_id, task_state, result_priority,
                    active_count, fail_count, input ready);
    modport sink   (input valid, status, result_id, task_state, result_priority,
                    active_count, fail_count, output ready);
endinterface

/* rtl/core/prt_cell.sv */
module prt_cell #(
    parameter int IDX = 0,
    parameter int CW  = 9
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  prt_pkg::t_cell_cmd i_cmd,
    input  logic [CW-1:0]      i_used,
    input  prt_pkg::t_cand     i_cand,
    input  logic               i_cand_vld,
    output prt_pkg::t_cand     o_cand,
    output logic               o_cand_vld,
    output logic [2:0]         o_state,
    output logic [7:0]         o_prio
);
    import prt_pkg::*;

    logic [ST_W-1:0]   r_state;
    logic [PRIO_W-1:0] r_prio;
    t_cand             r_cand;
    logic              r_cand_vld;
    logic              w_live;
    logic              w_hit;
    logic              w_take;

    assign w_live = (i_used > CW'(IDX));
    assign w_hit  = (i_cmd.slot == SLOT_W'(IDX));

    // apply broadcast commands to this slot
    always_ff @(posedge i_clk) begin
        case (i_cmd.op)
            CMD_WRITE: begin
                if (w_hit) begin
                    r_state <= i_cmd.state;
                    r_prio  <= i_cmd.prio;
                end
            end
            CMD_SET_STATE: begin
                if (w_hit) begin
                    r_state <= i_cmd.state;
                end
            end
            CMD_CANCEL_ALL: begin
                if (w_live && (r_state == ST_PENDING || r_state == ST_RUNNING)) begin
                    r_state <= ST_CANCELLED;
                end
            end
            default: begin
            end
        endcase
    end

    // replace the candidate only on a strictly higher priority
    assign w_take = w_live && (r_state == ST_PENDING)
                    && (!i_cand.found || (r_prio > i_cand.prio));

    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_cand <= '{found: 1'b1, prio: r_prio, slot: SLOT_W'(IDX)};
        end else begin
            r_cand <= i_cand;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cand_vld <= 1'b0;
        end else begin
            r_cand_vld <= i_cand_vld;
        end
    end

    assign o_cand     = r_cand;
    assign o_cand_vld = r_cand_vld;
    assign o_state    = r_state;
    assign o_prio     = r_prio;

endmodule

/* rtl/core/prt_chain.sv */
module prt_chain #(
    parameter int TABLE_DEPTH = prt_pkg::TABLE_DEPTH_DEF,
    parameter int IW          = $clog2(TABLE_DEPTH),
    parameter int CW          = $clog2(TABLE_DEPTH + 1)
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  prt_pkg::t_cell_cmd i_cmd,
    input  logic [CW-1:0]      i_used,
    input  logic               i_scan_start,
    output prt_pkg::t_cand     o_best,
    output logic               o_best_vld,
    input  logic [IW-1:0]      i_rd_idx,
    output logic [2:0]         o_rd_state,
    output logic [7:0]         o_rd_prio
);
    import prt_pkg::*;

    t_cand             w_cand     [TABLE_DEPTH+1];
    logic              w_cand_vld [TABLE_DEPTH+1];
    logic [ST_W-1:0]   w_state    [TABLE_DEPTH];
    logic [PRIO_W-1:0] w_prio     [TABLE_DEPTH];

    // scan enters the first cell with no candidate
    assign w_cand[0]     = '0;
    assign w_cand_vld[0] = i_scan_start;

    for (genvar g = 0; g < TABLE_DEPTH; g++) begin : g_cell
        prt_cell #(
            .IDX (g),
            .CW  (CW)
        ) u_cell (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_cmd      (i_cmd),
            .i_used     (i_used),
            .i_cand     (w_cand[g]),
            .i_cand_vld (w_cand_vld[g]),
            .o_cand     (w_cand[g+1]),
            .o_cand_vld (w_cand_vld[g+1]),
            .o_state    (w_state[g]),
            .o_prio     (w_prio[g])
        );
    end

    assign o_best     = w_cand[TABLE_DEPTH];
    assign o_best_vld = w_cand_vld[TABLE_DEPTH];

    // read port for the addressed slot
    assign o_rd_state = w_state[i_rd_idx];
    assign o_rd_prio  = w_prio[i_rd_idx];

endmodule

/* rtl/core/priority_task_table_top.sv */
// Priority task table: static-priority scheduler over TABLE_DEPTH slots.
// Requests arrive on i_req (opcode, task_id, priority_req, task_ok) and each
// one yields exactly one response on o_rsp (status, result_id, task_state,
// result_priority, active_count, fail_count), in request order.
// The slots live in a row of cells; a dispatch sends a candidate token down
// the row, each cell keeping the better of its own pending task and the
// one handed in and registering it, so the winner leaves the last cell.
// Each request steps from accept through execute and respond into the output
// register; a dispatch first waits in the scan step for the row traversal.
// One request is in flight at a time; the next request is taken as soon as
// the previous response sits in the output register, even while the
// receiver stalls it. A stalled response holds its value until taken, and a
// following request then waits in its last step.
// After reset the table is empty and open, counts are zero and nothing
// runs; slot contents are left as they are and only slots below the fill
// count are ever read.
module priority_task_table_top #(
    parameter int TABLE_DEPTH = prt_pkg::TABLE_DEPTH_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    prt_req_if.sink       i_req,
    prt_rsp_if.source     o_rsp
);
    import prt_pkg::*;

    localparam int IW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CW = $clog2(TABLE_DEPTH + 1);
    localparam int XW = (CW > ID_W) ? CW : ID_W;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_SCAN = 3'd1;
    localparam logic [2:0] S_EXEC = 3'd2;
    localparam logic [2:0] S_OUT  = 3'd3;

    logic [2:0]        r_fsm;
    logic [OP_W-1:0]   r_op;
    logic [ID_W-1:0]   r_id;
    logic [PRIO_W-1:0] r_prio;
    logic              r_ok;
    logic [IW-1:0]     r_slot;
    logic              r_found;
    logic              r_start;
    logic [CW-1:0]     r_used;
    logic [CW-1:0]     r_active;
    logic [CNT_W-1:0]  r_err;
    logic [CW-1:0]     r_run;
    logic              r_open;
    logic [2:0]        r_status;
    logic [XW-1:0]     r_rid;

    logic              r_o_valid;
    logic [2:0]        r_o_status;
    logic [ID_W-1:0]   r_o_id;
    logic [ST_W-1:0]   r_o_state;
    logic [PRIO_W-1:0] r_o_prio;
    logic [CNT_W-1:0]  r_o_active;
    logic [CNT_W-1:0]  r_o_err;

    logic              w_accept;
    logic              w_is_id;
    t_cell_cmd         w_cmd;
    t_cand             w_best;
    logic              w_best_vld;
    logic [ST_W-1:0]   w_rd_state;
    logic [PRIO_W-1:0] w_rd_prio;
    logic [XW-1:0]     w_act_x;

    logic [2:0]        n_status;
    logic [XW-1:0]     n_rid;
    logic [CW-1:0]     n_used;
    logic [CW-1:0]     n_active;
    logic [CNT_W-1:0]  n_err;
    logic [CW-1:0]     n_run;
    logic              n_open;

    assign i_req.ready = (r_fsm == S_IDLE);
    assign w_accept    = i_req.valid && i_req.ready;
    assign w_is_id     = (r_id != '0) && (XW'(r_id) <= XW'(r_used));

    prt_chain #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .IW          (IW),
        .CW          (CW)
    ) u_chain (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (w_cmd),
        .i_used       (r_used),
        .i_scan_start (r_start),
        .o_best       (w_best),
        .o_best_vld   (w_best_vld),
        .i_rd_idx     (r_slot),
        .o_rd_state   (w_rd_state),
        .o_rd_prio    (w_rd_prio)
    );

    // decide the operation against the table as it stands
    always_comb begin
        n_status = RC_OK;
        n_rid    = '0;
        n_used   = r_used;
        n_active = r_active;
        n_err    = r_err;
        n_run    = r_run;
        n_open   = r_open;
        w_cmd    = '{op: CMD_NONE, slot: SLOT_W'(r_slot), state: ST_PENDING, prio: r_prio};
        if (r_fsm == S_EXEC) begin
            case (r_op)
                OP_SCHEDULE: begin
                    if (!r_open) begin
                        n_status = RC_STOPPED;
                    end else if (r_used == CW'(TABLE_DEPTH)) begin
                        n_status = RC_FULL;
                    end else begin
                        w_cmd.op = CMD_WRITE;
                        n_used   = r_used + 1'b1;
                        n_active = r_active + 1'b1;
                        n_rid    = XW'(r_used) + 1'b1;
                    end
                end
                OP_DISPATCH: begin
                    if (!r_found) begin
                        n_status = RC_NONE_PENDING;
                    end else begin
                        w_cmd.op    = CMD_SET_STATE;
                        w_cmd.state = ST_RUNNING;
                        n_run       = CW'(r_slot) + 1'b1;
                        n_rid       = XW'(r_slot) + 1'b1;
                    end
                end
                OP_FINISH: begin
                    n_run = '0;
                    if (r_run == '0) begin
                        n_status = RC_NONE_RUNNING;
                    end else begin
                        n_rid = XW'(r_run);
                        if (w_rd_state != ST_RUNNING) begin
                            n_status = RC_OVER;
                        end else begin
                            w_cmd.op = CMD_SET_STATE;
                            n_active = r_active - 1'b1;
                            if (r_ok) begin
                                w_cmd.state = ST_DONE;
                            end else begin
                                w_cmd.state = ST_ERROR;
                                if (r_err != ERR_MAX) begin
                                    n_err = r_err + 1'b1;
                                end
                            end
                        end
                    end
                end
                OP_CANCEL: begin
                    if (!w_is_id) begin
                        n_status = RC_NOT_FOUND;
                    end else begin
                        n_rid = XW'(r_id);
                        if (w_rd_state == ST_PENDING || w_rd_state == ST_RUNNING) begin
                            w_cmd.op    = CMD_SET_STATE;
                            w_cmd.state = ST_CANCELLED;
                            n_active    = r_active - 1'b1;
                            if (XW'(r_run) == XW'(r_id)) begin
                                n_run = '0;
                            end
                        end else begin
                            n_status = RC_OVER;
                        end
                    end
                end
                OP_QUERY: begin
                    if (!w_is_id) begin
                        n_status = RC_NOT_FOUND;
                    end else begin
                        n_rid = XW'(r_id);
                    end
                end
                OP_CANCEL_ALL: begin
                    w_cmd.op = CMD_CANCEL_ALL;
                    n_active = '0;
                    n_run    = '0;
                    n_open   = 1'b0;
                end
                OP_CLEAR: begin
                    n_used   = '0;
                    n_active = '0;
                    n_err    = '0;
                    n_run    = '0;
                    n_open   = 1'b1;
                end
                default: begin
                end
            endcase
        end
    end

    // sequence one request: take, scan (dispatch only), execute, respond
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fsm    <= S_IDLE;
            r_start  <= 1'b0;
            r_used   <= '0;
            r_active <= '0;
            r_err    <= '0;
            r_run    <= '0;
            r_open   <= 1'b1;
        end else begin
            r_start <= 1'b0;
            case (r_fsm)
                S_IDLE: begin
                    if (w_accept) begin
                        if (i_req.opcode == OP_DISPATCH) begin
                            r_start <= 1'b1;
                            r_fsm   <= S_SCAN;
                        end else begin
                            r_fsm <= S_EXEC;
                        end
                    end
                end
                S_SCAN: begin
                    if (w_best_vld) begin
                        r_fsm <= S_EXEC;
                    end
                end
                S_EXEC: begin
                    r_used   <= n_used;
                    r_active <= n_active;
                    r_err    <= n_err;
                    r_run    <= n_run;
                    r_open   <= n_open;
                    r_fsm    <= S_OUT;
                end
                S_OUT: begin
                    if (!r_o_valid || o_rsp.ready) begin
                        r_fsm <= S_IDLE;
                    end
                end
                default: begin
                    r_fsm <= S_IDLE;
                end
            endcase
        end
    end

    // hold the request fields and the slot under work
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_op   <= i_req.opcode;
            r_id   <= i_req.task_id;
            r_prio <= i_req.priority_req;
            r_ok   <= i_req.task_ok;
            case (i_req.opcode)
                OP_SCHEDULE: r_slot <= r_used[IW-1:0];
                OP_FINISH:   r_slot <= IW'(r_run - 1'b1);
                default:     r_slot <= IW'(i_req.task_id - 1'b1);
            endcase
        end else if (r_fsm == S_SCAN && w_best_vld) begin
            r_found <= w_best.found;
            r_slot  <= w_best.slot[IW-1:0];
        end
        if (r_fsm == S_EXEC) begin
            r_status <= n_status;
            r_rid    <= n_rid;
        end
    end

    // output register, loaded after the cells took the command
    assign w_act_x = XW'(r_active);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (r_fsm == S_OUT && (!r_o_valid || o_rsp.ready)) begin
            r_o_valid <= 1'b1;
        end else if (o_rsp.ready) begin
            r_o_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_fsm == S_OUT && (!r_o_valid || o_rsp.ready)) begin
            r_o_status <= r_status;
            r_o_id     <= r_rid[ID_W-1:0];
            r_o_state  <= (r_rid != '0) ? w_rd_state : ST_PENDING;
            r_o_prio   <= (r_rid != '0) ? w_rd_prio : '0;
            r_o_active <= w_act_x[CNT_W-1:0];
            r_o_err    <= r_err;
        end
    end

    assign o_rsp.valid           = r_o_valid;
    assign o_rsp.status          = r_o_status;
    assign o_rsp.result_id       = r_o_id;
    assign o_rsp.task_state      = r_o_state;
    assign o_rsp.result_priority = r_o_prio;
    assign o_rsp.active_count    = r_o_active;
    assign o_rsp.fail_count      = r_o_err;

    // checks on the sequencer and the counters
    a_ready_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_fsm != S_IDLE) |-> !i_req.ready)
        else $error("request taken while busy");

    a_active_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_active <= r_used)
        else $error("active count above fill count");

    a_run_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_run <= r_used)
        else $error("running slot beyond fill count");

    a_rsp_from_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_o_valid) |-> $past(r_fsm) == S_OUT)
        else $error("response raised outside the respond step");

    a_scan_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_start |-> (r_fsm == S_SCAN) && (r_op == OP_DISPATCH))
        else $error("scan started without a dispatch");

endmodule

/* verif/priority_task_table_top_tb.sv */
module priority_task_table_top_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import prt_pkg::*;

    localparam int DEPTH       = 256;
    localparam int N_RANDOM    = 1530;
    localparam int STALL_LIMIT = 20000;
    localparam logic [2:0] OP_UNUSED = 3'd7;

    typedef struct packed {
        logic [2:0] status;
        logic [8:0] rid;
        logic [2:0] tstate;
        logic [7:0] prio;
        logic [8:0] active;
        logic [8:0] fails;
    } t_answer;

    typedef struct {
        logic [2:0] op;
        logic [8:0] id;
        logic [7:0] prio;
        logic       ok;
        bit         fixed;
        t_answer    answer;
    } t_row;

    logic i_clk;
    logic i_rst_n;

    prt_req_if req_if();
    prt_rsp_if rsp_if();

    priority_task_table_top #(.TABLE_DEPTH(DEPTH)) dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_req  (req_if.sink),
        .o_rsp  (rsp_if.source)
    );

    // shadow of the task table
    logic [2:0] tbl_state [DEPTH];
    logic [7:0] tbl_prio  [DEPTH];
    int         fill;
    int         fail_total;
    int         run_slot;
    bit         is_open;

    t_answer pending_answers[$];
    int      mismatches;
    int      idle_cycles;
    bit      timed_out;
    bit      hold_off;

    initial begin
        i_clk = 1'b0;
    end
    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    function automatic int live_tasks();
        int n;
        n = 0;
        for (int i = 0; i < fill; i++) begin
            if (tbl_state[i] == ST_PENDING || tbl_state[i] == ST_RUNNING) n++;
        end
        return n;
    endfunction

    // advance the shadow table by one request and return its answer
    function automatic t_answer table_step(logic [2:0] op, logic [8:0] id,
                                           logic [7:0] prio, logic ok);
        t_answer a;
        int      r;
        int      best;
        r = 0;
        best = -1;
        a = '0;
        a.status = RC_OK;
        case (op)
            OP_SCHEDULE: begin
                if (!is_open) a.status = RC_STOPPED;
                else if (fill >= DEPTH) a.status = RC_FULL;
                else begin
                    tbl_state[fill] = ST_PENDING;
                    tbl_prio[fill] = prio;
                    fill++;
                    r = fill;
                end
            end
            OP_DISPATCH: begin
                for (int i = 0; i < fill; i++) begin
                    if (tbl_state[i] == ST_PENDING &&
                        (best < 0 || tbl_prio[i] > tbl_prio[best])) best = i;
                end
                if (best < 0) a.status = RC_NONE_PENDING;
                else begin
                    tbl_state[best] = ST_RUNNING;
                    run_slot = best + 1;
                    r = best + 1;
                end
            end
            OP_FINISH: begin
                if (run_slot == 0) a.status = RC_NONE_RUNNING;
                else begin
                    r = run_slot;
                    run_slot = 0;
                    if (tbl_state[r-1] != ST_RUNNING) a.status = RC_OVER;
                    else if (ok) tbl_state[r-1] = ST_DONE;
                    else begin
                        tbl_state[r-1] = ST_ERROR;
                        if (fail_total < 511) fail_total++;
                    end
                end
            end
            OP_CANCEL: begin
                if (id == 0 || id > fill) a.status = RC_NOT_FOUND;
                else begin
                    r = id;
                    if (tbl_state[r-1] == ST_PENDING || tbl_state[r-1] == ST_RUNNING) begin
                        tbl_state[r-1] = ST_CANCELLED;
                        if (run_slot == r) run_slot = 0;
                    end else a.status = RC_OVER;
                end
            end
            OP_QUERY: begin
                if (id == 0 || id > fill) a.status = RC_NOT_FOUND;
                else r = id;
            end
            OP_CANCEL_ALL: begin
                for (int i = 0; i < fill; i++) begin
                    if (tbl_state[i] == ST_PENDING || tbl_state[i] == ST_RUNNING)
                        tbl_state[i] = ST_CANCELLED;
                end
                run_slot = 0;
                is_open = 1'b0;
            end
            OP_CLEAR: begin
                fill = 0;
                fail_total = 0;
                run_slot = 0;
                is_open = 1'b1;
            end
            default: ;
        endcase
        a.rid = r[8:0];
        if (r != 0) begin
            a.tstate = tbl_state[r-1];
            a.prio = tbl_prio[r-1];
        end
        a.active = 9'(live_tasks());
        a.fails = fail_total[8:0];
        return a;
    endfunction

    // mostly short gaps, a few long ones, often none
    function automatic int gap_len();
        int p;
        p = $urandom_range(0, 99);
        if (p < 50) return 0;
        if (p < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    task automatic send_request(logic [2:0] op, logic [8:0] id, logic [7:0] prio,
                                logic ok);
        int g;
        g = gap_len();
        if (g > 0) begin
            req_if.valid <= 1'b0;
            repeat (g) @(posedge i_clk);
        end
        req_if.valid        <= 1'b1;
        req_if.opcode       <= op;
        req_if.task_id      <= id;
        req_if.priority_req <= prio;
        req_if.task_ok      <= ok;
        @(posedge i_clk);
        while (!req_if.ready) @(posedge i_clk);
    endtask

    function automatic t_answer fixed_answer(logic [2:0] st, logic [8:0] rid,
                                             logic [2:0] ts, logic [7:0] pr,
                                             logic [8:0] ac, logic [8:0] fc);
        t_answer a;
        a = '{status: st, rid: rid, tstate: ts, prio: pr, active: ac, fails: fc};
        return a;
    endfunction

    // directed rows, a fill and a drain of the table, then random traffic
    task automatic run_requests();
        t_row    rows[$];
        t_answer want;
        int      p;
        logic [2:0] op;
        logic [8:0] id;
        rows.push_back('{OP_DISPATCH, 9'd0, 8'd0, 1'b1, 1'b1,
                         fixed_answer(RC_NONE_PENDING, 0, 0, 0, 0, 0)});
        rows.push_back('{OP_FINISH, 9'd0, 8'd0, 1'b1, 1'b1,
                         fixed_answer(RC_NONE_RUNNING, 0, 0, 0, 0, 0)});
        rows.push_back('{OP_QUERY, 9'd0, 8'd0, 1'b0, 1'b1,
                         fixed_answer(RC_NOT_FOUND, 0, 0, 0, 0, 0)});
        rows.push_back('{OP_SCHEDULE, 9'd0, 8'd255, 1'b0, 1'b1,
                         fixed_answer(RC_OK, 1, ST_PENDING, 255, 1, 0)});
        rows.push_back('{OP_SCHEDULE, 9'd0, 8'd0, 1'b0, 1'b1,
                         fixed_answer(RC_OK, 2, ST_PENDING, 0, 2, 0)});
        rows.push_back('{OP_SCHEDULE, 9'h1FF, 8'd255, 1'b1, 1'b0, '0});
        rows.push_back('{OP_CANCEL, 9'h1FF, 8'hFF, 1'b1, 1'b1,
                         fixed_answer(RC_NOT_FOUND, 0, 0, 0, 3, 0)});
        rows.push_back('{OP_DISPATCH, 9'd0, 8'd0, 1'b0, 1'b0, '0});
        rows.push_back('{OP_DISPATCH, 9'd0, 8'd0, 1'b0, 1'b0, '0});
        rows.push_back('{OP_FINISH, 9'd0, 8'd0, 1'b0, 1'b0, '0});
        rows.push_back('{OP_CANCEL, 9'd1, 8'd0, 1'b0, 1'b0, '0});
        rows.push_back('{OP_QUERY, 9'd3, 8'd0, 1'b0, 1'b0, '0});
        rows.push_back('{OP_CANCEL, 9'd2, 8'd0, 1'b0, 1'b0, '0});
        rows.push_back('{OP_CANCEL, 9'd2, 8'd0, 1'b0, 1'b0, '0});
        rows.push_back('{OP_DISPATCH, 9'd0, 8'd0, 1'b0, 1'b0, '0});
        rows.push_back('{OP_CANCEL, 9'd3, 8'd0, 1'b0, 1'b0, '0});
        rows.push_back('{OP_FINISH, 9'd0, 8'd0, 1'b1, 1'b0, '0});
        rows.push_back('{OP_UNUSED, 9'h155, 8'hAA, 1'b1, 1'b0, '0});
        rows.push_back('{OP_CANCEL_ALL, 9'd0, 8'd0, 1'b0, 1'b0, '0});
        rows.push_back('{OP_CANCEL_ALL, 9'd0, 8'd0, 1'b0, 1'b0, '0});
        rows.push_back('{OP_SCHEDULE, 9'd0, 8'd7, 1'b0, 1'b1,
                         fixed_answer(RC_STOPPED, 0, 0, 0, 0, 1)});
        rows.push_back('{OP_CLEAR, 9'd0, 8'd0, 1'b0, 1'b1,
                         fixed_answer(RC_OK, 0, 0, 0, 0, 0)});
        foreach (rows[i]) begin
            want = table_step(rows[i].op, rows[i].id, rows[i].prio, rows[i].ok);
            if (rows[i].fixed && want != rows[i].answer)
                $display("shadow table disagrees with directed row %0d", i);
            pending_answers.push_back(rows[i].fixed ? rows[i].answer : want);
            send_request(rows[i].op, rows[i].id, rows[i].prio, rows[i].ok);
        end
        // fill the table to the brim and overflow it, with random gaps between requests
        for (int i = 0; i < DEPTH + 3; i++) begin
            pending_answers.push_back(table_step(OP_SCHEDULE, 0, 8'($urandom), 0));
            send_request(OP_SCHEDULE, 0, tbl_prio[(i < DEPTH) ? i : 0], 0);
        end
        // drain a chunk of the full table, errors included
        for (int i = 0; i < 40; i++) begin
            op = (i % 2) ? OP_FINISH : OP_DISPATCH;
            pending_answers.push_back(table_step(op, 0, 0, i[1]));
            send_request(op, 0, 0, i[1]);
        end
        pending_answers.push_back(table_step(OP_CLEAR, 0, 0, 0));
        send_request(OP_CLEAR, 0, 0, 0);
        // random traffic, weighted toward working sequences in small tables
        for (int n = 0; n < N_RANDOM; n++) begin
            p = $urandom_range(0, 99);
            if (p < 30) op = OP_SCHEDULE;
            else if (p < 45) op = OP_DISPATCH;
            else if (p < 62) op = OP_FINISH;
            else if (p < 72) op = OP_CANCEL;
            else if (p < 86) op = OP_QUERY;
            else if (p < 89) op = OP_CANCEL_ALL;
            else if (p < 97) op = OP_CLEAR;
            else op = OP_UNUSED;
            if ($urandom_range(0, 9) == 0) id = 9'($urandom);
            else id = 9'($urandom_range(0, fill + 1));
            if (n == N_RANDOM / 2) hold_off = 1'b1;
            begin
                logic [7:0] pr;
                logic       okb;
                pr = 8'($urandom);
                okb = 1'($urandom);
                pending_answers.push_back(table_step(op, id, pr, okb));
                send_request(op, id, pr, okb);
            end
        end
    endtask

    // receiver: random stalls, one long hold-off on request
    initial begin
        rsp_if.ready = 1'b0;
        @(posedge i_rst_n);
        forever begin
            if (hold_off) begin
                rsp_if.ready <= 1'b0;
                hold_off = 1'b0;
                repeat (300) @(posedge i_clk);
            end
            rsp_if.ready <= (gap_len() == 0);
            @(posedge i_clk);
        end
    end

    // compare every accepted response with the oldest prediction
    always @(posedge i_clk) begin
        t_answer got;
        t_answer want;
        if (i_rst_n && rsp_if.valid && rsp_if.ready) begin
            got = '{status: rsp_if.status, rid: rsp_if.result_id,
                    tstate: rsp_if.task_state, prio: rsp_if.result_priority,
                    active: rsp_if.active_count, fails: rsp_if.fail_count};
            if (pending_answers.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected response %p", got);
            end else begin
                want = pending_answers.pop_front();
                if (got !== want) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("response mismatch: expected %p, got %p", want, got);
                end
            end
        end
    end

    // watchdog on cycles with no handshake
    always @(posedge i_clk) begin
        if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT && !timed_out) begin
            timed_out = 1'b1;
            $display("priority_task_table_top_tb: errors");
            $finish;
        end
    end

    initial begin
        req_if.valid        = 1'b0;
        req_if.opcode       = OP_SCHEDULE;
        req_if.task_id      = '0;
        req_if.priority_req = '0;
        req_if.task_ok      = 1'b0;
        i_rst_n     = 1'b0;
        mismatches  = 0;
        idle_cycles = 0;
        timed_out   = 1'b0;
        hold_off    = 1'b0;
        fill        = 0;
        fail_total  = 0;
        run_slot    = 0;
        is_open     = 1'b1;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        run_requests();
        req_if.valid <= 1'b0;
        while (pending_answers.size() != 0) @(posedge i_clk);
        repeat (DEPTH + 20) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("priority_task_table_top_tb: clean");
        end else begin
            $display("priority_task_table_top_tb: errors");
        end
        $finish;
    end
endmodule
